// ----- hdl/vams_pkg.sv -----
// ----------------------------------------------------------------------------
// vams_pkg: shared constants for the arming and mode supervisor
// State, event, mode and result codes, flag bits, counter width and stream widths.
// ----------------------------------------------------------------------------
package vams_pkg;

  // Publish counter width (valid range 8 to 32).
  localparam int unsigned COUNT_WIDTH = 16;

  localparam int unsigned STATE_W  = 4;
  localparam int unsigned KIND_W   = 4;
  localparam int unsigned MODE_W   = 2;
  localparam int unsigned CODE_W   = 2;
  localparam int unsigned PUBOUT_W = 16;

  localparam int unsigned IN_DATA_W  = 24;
  localparam int unsigned IN_USER_W  = 4;
  localparam int unsigned OUT_DATA_W = 32;

  // System states
  localparam logic [STATE_W-1:0] ST_PREFLIGHT   = 4'd0;
  localparam logic [STATE_W-1:0] ST_STANDBY     = 4'd1;
  localparam logic [STATE_W-1:0] ST_GROUNDREADY = 4'd2;
  localparam logic [STATE_W-1:0] ST_MANUAL      = 4'd3;
  localparam logic [STATE_W-1:0] ST_STABILIZED  = 4'd4;
  localparam logic [STATE_W-1:0] ST_AUTO        = 4'd5;
  localparam logic [STATE_W-1:0] ST_ABORT       = 4'd6;
  localparam logic [STATE_W-1:0] ST_EMLANDING   = 4'd7;
  localparam logic [STATE_W-1:0] ST_CUTOFF      = 4'd8;
  localparam logic [STATE_W-1:0] ST_GROUNDERROR = 4'd9;
  localparam logic [STATE_W-1:0] ST_REBOOT      = 4'd10;

  // Event kinds
  localparam logic [KIND_W-1:0] EV_FIX        = 4'd0;
  localparam logic [KIND_W-1:0] EV_FIXLOST    = 4'd1;
  localparam logic [KIND_W-1:0] EV_EMERGENCY  = 4'd2;
  localparam logic [KIND_W-1:0] EV_CRITICAL   = 4'd3;
  localparam logic [KIND_W-1:0] EV_ARM        = 4'd4;
  localparam logic [KIND_W-1:0] EV_DISARM     = 4'd5;
  localparam logic [KIND_W-1:0] EV_MANUAL     = 4'd6;
  localparam logic [KIND_W-1:0] EV_STABILIZED = 4'd7;
  localparam logic [KIND_W-1:0] EV_AUTO       = 4'd8;
  localparam logic [KIND_W-1:0] EV_FLAGREQ    = 4'd9;
  localparam logic [KIND_W-1:0] EV_CUSTOMREQ  = 4'd10;

  // Flight modes
  localparam logic [MODE_W-1:0] MODE_MANUAL     = 2'd0;
  localparam logic [MODE_W-1:0] MODE_STABILIZED = 2'd1;
  localparam logic [MODE_W-1:0] MODE_AUTO       = 2'd2;

  // Result codes
  localparam logic [CODE_W-1:0] RES_OK        = 2'd0;
  localparam logic [CODE_W-1:0] RES_UNCHANGED = 2'd1;
  localparam logic [CODE_W-1:0] RES_HIL_DENY  = 2'd2;

  // Flag request bits
  localparam int unsigned FLAG_ARM_BIT = 7;
  localparam int unsigned FLAG_HIL_BIT = 5;

endpackage

// ----- hdl/vehicle_arming_mode_supervisor.sv -----
// ----------------------------------------------------------------------------
// vehicle_arming_mode_supervisor: vehicle safety and flight mode supervisor
// Applies one event per request to the system state, arming, HIL latch,
// flight mode and publish counter, and returns one status result per event.
// ----------------------------------------------------------------------------
// Path: an accepted request passes the input register, then the result
//   register, from which the result is offered.
// Throughput: one request per cycle; the transition table is evaluated in a
//   single pass. Input stalls only while both registers are full and the
//   result is not taken.
// Reset: rst_ni low clears both valid flags and puts the supervisor in
//   preflight, disarmed, HIL clear, manual mode, control off, count zero.
module vehicle_arming_mode_supervisor
  import vams_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // Input stream
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  // [7:0] request_flags, [15:8] requested_state, [16] radio_lost,
  // [17] offboard_lost, [23:18] zero
  input  logic [IN_DATA_W-1:0]  s_axis_tdata_i,
  // [3:0] event_kind
  input  logic [IN_USER_W-1:0]  s_axis_tuser_i,
  // Result stream
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  // [3:0] system_state, [4] armed, [5] lockdown, [6] hil_active,
  // [8:7] nav_mode, [9] control_enabled, [25:10] publish_count,
  // [26] reboot_request, [28:27] result_code, [31:29] zero
  output logic [OUT_DATA_W-1:0] m_axis_tdata_o
);

  // --------------------------------------------------------------------------
  // Input register
  // --------------------------------------------------------------------------
  logic                 in_valid_q;
  logic [IN_DATA_W-1:0] in_data_q;
  logic [KIND_W-1:0]    in_kind_q;
  logic                 out_valid_q;
  logic [OUT_DATA_W-1:0] out_data_q;

  logic advance;   // request in the input register moves to the result register

  assign advance         = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_data_q <= s_axis_tdata_i;
      in_kind_q <= s_axis_tuser_i;
    end
  end

  // Field unpack
  logic [7:0]         req_flags;
  logic [STATE_W-1:0] req_state_lo;
  logic               req_state_ok;   // upper bits of requested_state are zero
  logic               radio_lost;
  logic               offboard_lost;

  assign req_flags     = in_data_q[7:0];
  assign req_state_lo  = in_data_q[8 +: STATE_W];
  assign req_state_ok  = (in_data_q[15:8+STATE_W] == '0);
  assign radio_lost    = in_data_q[16];
  assign offboard_lost = in_data_q[17];

  // --------------------------------------------------------------------------
  // Supervisor state
  // --------------------------------------------------------------------------
  logic [STATE_W-1:0]     state_q, state_d;
  logic                   armed_q, armed_d;
  logic                   hil_q, hil_d;
  logic [MODE_W-1:0]      mode_q, mode_d;
  logic                   ctl_q, ctl_d;
  logic [COUNT_WIDTH-1:0] pub_cnt_q, pub_cnt_d;

  logic [1:0]        npub;      // publishes caused by this event, 0..2
  logic [CODE_W-1:0] code;
  logic              reboot;
  logic              want_arm;
  logic              want_hil;
  logic [MODE_W-1:0] sel_mode;
  logic              mode_hit;  // current state allows the mode entry
  logic [STATE_W-1:0] mode_target;

  assign want_arm = req_flags[FLAG_ARM_BIT];
  assign want_hil = req_flags[FLAG_HIL_BIT];

  // Mode event decode
  always_comb begin
    sel_mode    = MODE_MANUAL;
    mode_target = ST_MANUAL;
    mode_hit    = 1'b0;
    unique case (in_kind_q)
      EV_MANUAL: begin
        sel_mode    = MODE_MANUAL;
        mode_target = ST_MANUAL;
        mode_hit    = (state_q == ST_GROUNDREADY) || (state_q == ST_STABILIZED) ||
                      (state_q == ST_AUTO);
      end
      EV_STABILIZED: begin
        sel_mode    = MODE_STABILIZED;
        mode_target = ST_STABILIZED;
        mode_hit    = (state_q == ST_GROUNDREADY) || (state_q == ST_MANUAL) ||
                      (state_q == ST_AUTO);
      end
      EV_AUTO: begin
        sel_mode    = MODE_AUTO;
        mode_target = ST_AUTO;
        mode_hit    = (state_q == ST_GROUNDREADY) || (state_q == ST_MANUAL) ||
                      (state_q == ST_STABILIZED);
      end
      default: begin
        sel_mode    = MODE_MANUAL;
        mode_target = ST_MANUAL;
        mode_hit    = 1'b0;
      end
    endcase
  end

  // Transition table
  always_comb begin
    state_d = state_q;
    armed_d = armed_q;
    hil_d   = hil_q;
    mode_d  = mode_q;
    ctl_d   = ctl_q;
    npub    = 2'd0;
    reboot  = 1'b0;
    code    = RES_UNCHANGED;

    unique case (in_kind_q)
      EV_FIX: begin
        if (state_q == ST_PREFLIGHT) begin
          state_d = ST_STANDBY;
          armed_d = 1'b0;
          npub    = 2'd1;
        end
      end
      EV_FIXLOST, EV_EMERGENCY, EV_CRITICAL: begin
        // fixlost only from standby/groundready/auto; emergency skips manual
        if ((in_kind_q == EV_CRITICAL) ||
            ((in_kind_q == EV_EMERGENCY) && (state_q != ST_MANUAL)) ||
            ((in_kind_q == EV_FIXLOST) &&
             ((state_q == ST_STANDBY) || (state_q == ST_GROUNDREADY) ||
              (state_q == ST_AUTO)))) begin
          if ((state_q == ST_PREFLIGHT) || (state_q == ST_STANDBY) ||
              (state_q == ST_GROUNDREADY)) begin
            state_d = ST_GROUNDERROR;
            armed_d = 1'b0;
            npub    = 2'd1;
          end else if ((state_q == ST_AUTO) || (state_q == ST_MANUAL)) begin
            // abort passes through emergency landing: two publishes
            state_d = ST_ABORT;
            armed_d = 1'b1;
            npub    = 2'd2;
          end
        end
      end
      EV_ARM: begin
        if (state_q == ST_STANDBY) begin
          state_d = ST_GROUNDREADY;
          armed_d = 1'b1;
          npub    = 2'd1;
        end
      end
      EV_DISARM: begin
        if ((state_q == ST_GROUNDREADY) || (state_q == ST_MANUAL) ||
            (state_q == ST_PREFLIGHT) || (state_q == ST_STABILIZED) ||
            (state_q == ST_AUTO)) begin
          state_d = ST_STANDBY;
          armed_d = 1'b0;
          npub    = 2'd1;
        end
      end
      EV_MANUAL, EV_STABILIZED, EV_AUTO: begin
        mode_d = sel_mode;
        ctl_d  = 1'b1;
        npub   = {(mode_hit && (mode_q != sel_mode)),
                  (mode_hit != (mode_q != sel_mode))};
        if (mode_hit) begin
          state_d = mode_target;
          armed_d = 1'b1;
        end
      end
      EV_FLAGREQ: begin
        // arm step, then disarm step (mutually exclusive via want_arm),
        // then the HIL latch, each seeing what the previous left
        if (!armed_q && want_arm &&
            ((state_q == ST_STANDBY) || (state_q == ST_PREFLIGHT))) begin
          state_d = ST_GROUNDREADY;
          armed_d = 1'b1;
          npub    = 2'd1;
          code    = RES_OK;
        end else if (armed_q && !want_arm && (state_q == ST_GROUNDREADY)) begin
          state_d = ST_STANDBY;
          armed_d = 1'b0;
          npub    = 2'd1;
          code    = RES_OK;
        end
        if ((state_d == ST_STANDBY) && want_hil && !hil_q) begin
          hil_d = 1'b1;
          npub  = npub + 2'd1;
          code  = RES_OK;
        end
        if (hil_d && !want_hil) begin
          code = RES_HIL_DENY;
        end
      end
      EV_CUSTOMREQ: begin
        if (req_state_ok && (req_state_lo == ST_REBOOT) &&
            ((state_q == ST_STANDBY) || (state_q == ST_PREFLIGHT))) begin
          state_d = ST_REBOOT;
          armed_d = 1'b0;
          reboot  = 1'b1;
          npub    = 2'd1;
          code    = RES_OK;
        end else if (req_state_ok && (req_state_lo == ST_AUTO) &&
                     ((state_q == ST_GROUNDREADY) || (state_q == ST_MANUAL))) begin
          state_d = ST_AUTO;
          armed_d = 1'b1;
          npub    = 2'd1;
          code    = RES_OK;
        end else if (req_state_ok && (req_state_lo == ST_MANUAL) &&
                     ((state_q == ST_GROUNDREADY) || (state_q == ST_AUTO))) begin
          state_d = ST_MANUAL;
          armed_d = 1'b1;
          npub    = 2'd1;
          code    = RES_OK;
        end
      end
      default: begin
        // unknown kinds leave everything alone
      end
    endcase

    // Events 0..8 report whether anything was published
    if (in_kind_q <= EV_AUTO) begin
      code = (npub != 2'd0) ? RES_OK : RES_UNCHANGED;
    end
  end

  assign pub_cnt_d = pub_cnt_q + COUNT_WIDTH'(npub);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_PREFLIGHT;
      armed_q   <= 1'b0;
      hil_q     <= 1'b0;
      mode_q    <= MODE_MANUAL;
      ctl_q     <= 1'b0;
      pub_cnt_q <= '0;
    end else if (advance) begin
      state_q   <= state_d;
      armed_q   <= armed_d;
      hil_q     <= hil_d;
      mode_q    <= mode_d;
      ctl_q     <= ctl_d;
      pub_cnt_q <= pub_cnt_d;
    end
  end

  // --------------------------------------------------------------------------
  // Result register
  // --------------------------------------------------------------------------
  logic [31:0]               pub_cnt_ext;
  logic [OUT_DATA_W-1:0]     out_data_d;

  assign pub_cnt_ext = 32'(pub_cnt_d);

  assign out_data_d = {3'b000, code, reboot, pub_cnt_ext[PUBOUT_W-1:0], ctl_d, mode_d,
                       hil_d, ((radio_lost && offboard_lost) || hil_d), armed_d, state_d};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_data_q <= out_data_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

endmodule

// ----- hdl/vams_checker.sv -----
// ----------------------------------------------------------------------------
// vams_checker: port-level checks for the arming and mode supervisor
// Watches the result stream for reset, stall and status consistency.
// ----------------------------------------------------------------------------
module vams_checker
  import vams_pkg::*;
(
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  s_axis_tvalid_i,
  input logic                  s_axis_tready_o,
  input logic                  m_axis_tvalid_o,
  input logic                  m_axis_tready_i,
  input logic [OUT_DATA_W-1:0] m_axis_tdata_o
);

  // No result is offered while reset is held.
  a_reset_quiet: assert property (@(posedge clk_i) !rst_ni |-> !m_axis_tvalid_o)
    else $error("result valid during reset");

  // A stalled result stays put.
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("stalled result changed");

  // Once an accepted request has passed the input register, a result is always on offer.
  a_accept_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |-> ##2 m_axis_tvalid_o)
    else $error("accepted request produced no result");

  // Reboot pulse only with the reboot state and actuators disarmed.
  a_reboot_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tdata_o[26] |->
      (m_axis_tdata_o[3:0] == ST_REBOOT) && !m_axis_tdata_o[4])
    else $error("reboot request outside reboot state");

  // HIL latch forces lockdown.
  a_hil_lockdown: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tdata_o[6] |-> m_axis_tdata_o[5])
    else $error("hil active without lockdown");

endmodule

bind vehicle_arming_mode_supervisor vams_checker u_vams_checker (.*);
